/* hw/rtl/utf8v_pkg.sv */
// Package for the clean-text UTF-8 validator: byte constants, field widths and the
// structs passed between the top level and the decoder core.
// No dependencies.
`timescale 1ns / 1ps

package utf8v_pkg;

  localparam int unsigned LenW   = 16;
  localparam int unsigned CountW = LenW + 1;
  localparam int unsigned CpW    = 21;

  localparam logic [LenW-1:0] MaxLengthReset = 16'd64;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] CtrlLimit  = 8'h20;
  localparam logic [7:0] DelByte    = 8'h7F;

  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Val  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Val  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Val  = 8'hF0;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] ContVal   = 8'h80;

  localparam logic [CpW-1:0] Min2     = 21'h00080;
  localparam logic [CpW-1:0] Min3     = 21'h00800;
  localparam logic [CpW-1:0] Min4     = 21'h10000;
  localparam logic [CpW-1:0] MaxCp    = 21'h10FFFF;
  localparam logic [CpW-1:0] SurrLow  = 21'h0D800;
  localparam logic [CpW-1:0] SurrHigh = 21'h0DFFF;

  // Number of continuation bytes that follow a lead byte.
  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
    logic       no_byte;
  } utf8v_item_t;

  typedef struct packed {
    logic fire;
    logic ok;
  } utf8v_verdict_t;

endpackage

/* hw/rtl/utf8v_if.sv */
// Valid/ready channel interfaces for the validator's byte input and verdict output.
// Depends on nothing; the payload widths follow the field list of the block.
`timescale 1ns / 1ps

interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       no_byte;

  modport source (output valid, output data_byte, output is_last, output no_byte,
                  input ready);
  modport sink   (input valid, input data_byte, input is_last, input no_byte,
                  output ready);
endinterface

interface utf8v_out_if;
  logic valid;
  logic ready;
  logic valid_res;

  modport source (output valid, output valid_res, input ready);
  modport sink   (input valid, input valid_res, output ready);
endinterface

/* hw/rtl/utf8v_core.sv */
// Decoder core of the validator: holds the per-string state and updates it by at most
// one byte per step, producing the verdict on the last item. Depends on utf8v_pkg.
`timescale 1ns / 1ps

module utf8v_core
  import utf8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step_en,
  input  utf8v_item_t     item,
  input  logic [LenW-1:0] max_length,
  output utf8v_verdict_t  verdict
);

  logic [1:0]        pending_r, pending_nxt;
  logic [1:0]        seq_len_r, seq_len_nxt;
  logic [CpW-1:0]    cp_r, cp_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic              failed_r, failed_nxt;

  logic [1:0]        pend_b;
  logic [1:0]        seq_b;
  logic [CpW-1:0]    cp_b;
  logic [CountW-1:0] count_b;
  logic              failed_b;
  logic [CountW-1:0] limit;
  logic [CpW-1:0]    cp_shift;
  logic [CpW-1:0]    cp_min;
  logic [7:0]        b;

  assign b        = item.data_byte;
  assign limit    = {1'b0, max_length} + CountW'(1);
  assign cp_shift = {cp_r[CpW-7:0], b[5:0]};

  always_comb begin
    unique case (seq_len_r)
      SeqTwo:   cp_min = Min2;
      SeqThree: cp_min = Min3;
      default:  cp_min = Min4;
    endcase
  end

  // State after the byte of this item has been taken in.
  always_comb begin
    pend_b   = pending_r;
    seq_b    = seq_len_r;
    cp_b     = cp_r;
    count_b  = count_r;
    failed_b = failed_r;
    if (!item.no_byte) begin
      if (count_r < limit) begin
        count_b = count_r + CountW'(1);
      end
      if (!failed_r) begin
        if (pending_r == 2'd0) begin
          priority if (b < AsciiLimit) begin
            if (b < CtrlLimit || b == DelByte) begin
              failed_b = 1'b1;
            end
          end else if ((b & Lead2Mask) == Lead2Val) begin
            seq_b  = SeqTwo;
            pend_b = SeqTwo;
            cp_b   = CpW'(b[4:0]);
          end else if ((b & Lead3Mask) == Lead3Val) begin
            seq_b  = SeqThree;
            pend_b = SeqThree;
            cp_b   = CpW'(b[3:0]);
          end else if ((b & Lead4Mask) == Lead4Val) begin
            seq_b  = SeqFour;
            pend_b = SeqFour;
            cp_b   = CpW'(b[2:0]);
          end else begin
            failed_b = 1'b1;
          end
        end else if ((b & ContMask) != ContVal) begin
          failed_b = 1'b1;
        end else begin
          cp_b   = cp_shift;
          pend_b = pending_r - 2'd1;
          // The sequence is complete: reject overlong forms, surrogates and
          // anything beyond the last plane.
          if (pending_r == 2'd1) begin
            if (cp_shift < cp_min || cp_shift > MaxCp ||
                (cp_shift >= SurrLow && cp_shift <= SurrHigh)) begin
              failed_b = 1'b1;
            end
          end
        end
      end
    end
  end

  always_comb begin
    verdict.fire = step_en && item.is_last;
    verdict.ok   = !failed_b && pend_b == 2'd0 && count_b != '0 &&
                   count_b <= {1'b0, max_length};
    pending_nxt  = pending_r;
    seq_len_nxt  = seq_len_r;
    cp_nxt       = cp_r;
    count_nxt    = count_r;
    failed_nxt   = failed_r;
    if (step_en) begin
      if (item.is_last) begin
        pending_nxt = '0;
        seq_len_nxt = '0;
        cp_nxt      = '0;
        count_nxt   = '0;
        failed_nxt  = 1'b0;
      end else begin
        pending_nxt = pend_b;
        seq_len_nxt = seq_b;
        cp_nxt      = cp_b;
        count_nxt   = count_b;
        failed_nxt  = failed_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      seq_len_r <= '0;
      cp_r      <= '0;
      count_r   <= '0;
      failed_r  <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      seq_len_r <= seq_len_nxt;
      cp_r      <= cp_nxt;
      count_r   <= count_nxt;
      failed_r  <= failed_nxt;
    end
  end

  a_pending_within_seq: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= seq_len_r)
    else $error("pending continuation count exceeds sequence length");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    verdict.fire |=> (count_r == '0 && pending_r == 2'd0 && !failed_r))
    else $error("string state not cleared after a verdict");

endmodule

/* hw/rtl/utf8_clean_text_validator.sv */
// Top level of the clean-text UTF-8 validator: input register, decoder core,
// verdict register and the max_length register. Depends on utf8v_pkg, utf8v_if, utf8v_core.
//
//  Channel  Direction  Payload                        Transfer
//  in_ch    in         data_byte, is_last, no_byte    valid && ready
//  out_ch   out        valid_res                      valid && ready
//  cfg      in         cfg_wdata (max_length)         cfg_we
//
// One item is taken per cycle while the verdict register is not stalled; the last item
// of a string passes the input register and then the verdict register before its verdict
// is presented on out_ch. The string's state is five core registers updated on each step.
// A stalled verdict holds the pipeline; the input register frees as soon as the
// verdict register is empty or being taken. Reset clears all control state and
// sets max_length to 64.
`timescale 1ns / 1ps

module utf8_clean_text_validator
  import utf8v_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  utf8v_in_if.sink        in_ch,
  utf8v_out_if.source     out_ch,
  input  logic            cfg_we,
  input  logic [LenW-1:0] cfg_wdata
);

  logic            in_valid_r, in_valid_nxt;
  utf8v_item_t     item_r;
  logic            out_valid_r, out_valid_nxt;
  logic            out_res_r;
  logic [LenW-1:0] max_len_r;
  logic            advance;
  logic            step_en;
  logic            in_xfer;
  utf8v_verdict_t  verdict;

  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign step_en      = in_valid_r && advance;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.valid_res = out_res_r;

  utf8v_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (step_en),
    .item       (item_r),
    .max_length (max_len_r),
    .verdict    (verdict)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_xfer) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (verdict.fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      max_len_r   <= MaxLengthReset;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.data_byte <= in_ch.data_byte;
      item_r.is_last   <= in_ch.is_last;
      item_r.no_byte   <= in_ch.no_byte;
    end
    if (verdict.fire) begin
      out_res_r <= verdict.ok;
    end
  end

  a_verdict_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && item_r.is_last) |=> out_valid_r)
    else $error("verdict of a last item did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !step_en)
    else $error("core stepped while a verdict was stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!in_valid_r && !out_valid_r))
    else $error("pipeline not empty after reset");

endmodule

/* bench/tb_utf8_clean_text_validator.sv */
// Self-checking testbench for utf8_clean_text_validator: directed and random strings
// are driven through the byte channel and each verdict is checked against a predictor.
// Depends on utf8v_pkg, utf8v_if and the RTL of the validator.
`timescale 1ns / 1ps

module tb_utf8_clean_text_validator;
  import utf8v_pkg::*;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            cfg_we    = 1'b0;
  logic [LenW-1:0] cfg_wdata = '0;

  utf8v_in_if  in_ch();
  utf8v_out_if out_ch();

  utf8v_item_t in_item   = '0;
  logic        in_valid  = 1'b0;
  logic        res_ready = 1'b0;

  assign in_ch.valid     = in_valid;
  assign in_ch.data_byte = in_item.data_byte;
  assign in_ch.is_last   = in_item.is_last;
  assign in_ch.no_byte   = in_item.no_byte;
  assign out_ch.ready    = res_ready;

  utf8_clean_text_validator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state, a copy of what the decoder holds for the current string.
  logic [LenW-1:0]   lim_len    = MaxLengthReset;
  logic [1:0]        cont_left  = '0;
  logic [1:0]        cont_total = '0;
  logic [CpW-1:0]    cp_acc     = '0;
  logic [CountW-1:0] len_seen   = '0;
  logic              bad_seen   = 1'b0;
  bit                verdicts_due[$];

  utf8v_item_t pend_items[$];
  logic [7:0]  text_q[$];
  int unsigned items_loaded  = 0;
  int unsigned items_taken   = 0;
  int unsigned budget_items  = 0;
  int unsigned idle_pct      = 0;
  int unsigned stall_pct     = 0;
  bit          quiet_tail    = 1'b0;
  int unsigned fail_cnt      = 0;
  int unsigned verdicts_seen = 0;
  int unsigned verdicts_true = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic track_byte(input logic [7:0] b);
    logic [CpW-1:0] floor_cp;
    if (len_seen < {1'b0, lim_len} + 1'b1) begin
      len_seen = len_seen + 1'b1;
    end
    if (!bad_seen) begin
      if (cont_left == 2'd0) begin
        if (b < AsciiLimit) begin
          if (b < CtrlLimit || b == DelByte) bad_seen = 1'b1;
        end else if ((b & Lead2Mask) == Lead2Val) begin
          cont_total = SeqTwo;
          cp_acc     = {16'b0, b[4:0]};
          cont_left  = SeqTwo;
        end else if ((b & Lead3Mask) == Lead3Val) begin
          cont_total = SeqThree;
          cp_acc     = {17'b0, b[3:0]};
          cont_left  = SeqThree;
        end else if ((b & Lead4Mask) == Lead4Val) begin
          cont_total = SeqFour;
          cp_acc     = {18'b0, b[2:0]};
          cont_left  = SeqFour;
        end else begin
          bad_seen = 1'b1;
        end
      end else if ((b & ContMask) != ContVal) begin
        bad_seen = 1'b1;
      end else begin
        cp_acc    = {cp_acc[CpW-7:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          floor_cp = (cont_total == SeqTwo) ? Min2 : (cont_total == SeqThree) ? Min3 : Min4;
          if (cp_acc < floor_cp || cp_acc > MaxCp ||
              (cp_acc >= SurrLow && cp_acc <= SurrHigh)) begin
            bad_seen = 1'b1;
          end
        end
      end
    end
  endtask

  task automatic track_item(input utf8v_item_t it);
    if (!it.no_byte) track_byte(it.data_byte);
    if (it.is_last) begin
      verdicts_due.push_back(!bad_seen && cont_left == 2'd0 && len_seen != '0 &&
                             len_seen <= {1'b0, lim_len});
      cont_left  = '0;
      cont_total = '0;
      cp_acc     = '0;
      len_seen   = '0;
      bad_seen   = 1'b0;
    end
  endtask

  // Driver: a new item is presented once the previous one has been transferred.
  int unsigned gap_left = 0;
  utf8v_item_t cur_item = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready) begin
        track_item(cur_item);
        items_taken++;
      end
      if (!in_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_items.size() > 0) begin
          cur_item = pend_items.pop_front();
          in_item  <= cur_item;
          in_valid <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 99) < idle_pct) gap_left = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each verdict transfer and stalls the result channel in bursts.
  int unsigned stall_left = 0;
  bit          want_ok;

  always @(posedge clk) begin
    if (!rst_n) begin
      res_ready <= 1'b0;
    end else begin
      if (out_ch.valid && res_ready) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          $error("valid_res: expected none, actual %0b", out_ch.valid_res);
          fail_cnt++;
        end else begin
          want_ok = verdicts_due.pop_front();
          if (out_ch.valid_res !== want_ok) begin
            $error("valid_res: expected %0b, actual %0b", want_ok, out_ch.valid_res);
            fail_cnt++;
          end else if (want_ok) begin
            verdicts_true++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (!quiet_tail && $urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 8);
      end
    end
  end

  task automatic push_item(input logic [7:0] b, input logic last, input logic none);
    utf8v_item_t it;
    it.data_byte = b;
    it.is_last   = last;
    it.no_byte   = none;
    pend_items.push_back(it);
    items_loaded++;
    if (last || !none) budget_items++;
  endtask

  // Sends text_q as one string; the string may close on an item with no byte.
  task automatic emit_text(input bit gaps, input bit end_empty);
    bit close_empty;
    close_empty = end_empty || text_q.size() == 0;
    foreach (text_q[i]) begin
      if (gaps && $urandom_range(0, 9) == 0) push_item(8'($urandom), 1'b0, 1'b1);
      push_item(text_q[i], !close_empty && i == text_q.size() - 1, 1'b0);
    end
    if (close_empty) push_item(8'($urandom), 1'b1, 1'b1);
    text_q.delete();
  endtask

  task automatic put_char(input logic [CpW-1:0] cp, input int unsigned nb);
    case (nb)
      1: text_q.push_back(cp[7:0]);
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  function automatic logic [CpW-1:0] pick_cp(input int unsigned nb);
    logic [CpW-1:0] lo;
    logic [CpW-1:0] hi;
    logic [CpW-1:0] cp;
    case (nb)
      1: begin lo = 21'h20; hi = 21'h7E; end
      2: begin lo = Min2; hi = 21'h7FF; end
      3: begin lo = Min3; hi = 21'hFFFF; end
      default: begin lo = Min4; hi = MaxCp; end
    endcase
    if ($urandom_range(0, 7) == 0) cp = $urandom_range(0, 1) ? hi : lo;
    else cp = CpW'($urandom_range(lo, hi));
    // Surrogates are moved up into the private-use block above them.
    if (cp >= SurrLow && cp <= SurrHigh) cp = cp + 21'h800;
    return cp;
  endfunction

  task automatic put_good();
    int unsigned nb;
    nb = ($urandom_range(0, 4) < 2) ? 1 : $urandom_range(2, 4);
    put_char(pick_cp(nb), nb);
  endtask

  task automatic put_fault(output bit at_end);
    int unsigned nb;
    logic [7:0]  b;
    at_end = 1'b0;
    nb     = $urandom_range(2, 4);
    case ($urandom_range(0, 7))
      0: text_q.push_back($urandom_range(0, 1) ? DelByte : 8'($urandom_range(0, 8'h1F)));
      1: text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                               : 8'($urandom_range(8'hF8, 8'hFF)));
      2: begin
        put_char(pick_cp(nb), nb);
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        text_q[text_q.size() - $urandom_range(1, nb - 1)] = b;
      end
      3: begin
        put_char(pick_cp(nb), nb);
        repeat ($urandom_range(1, nb - 1)) void'(text_q.pop_back());
        at_end = 1'b1;
      end
      4: put_char(CpW'($urandom_range(0, (nb == 2) ? 32'h7F
                                        : (nb == 3) ? 32'h7FF : 32'hFFFF)), nb);
      5: put_char(CpW'($urandom_range(SurrLow, SurrHigh)), 3);
      6: put_char(CpW'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      default: repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom));
    endcase
  endtask

  task automatic load_random(input int unsigned count);
    int unsigned goal;
    int unsigned n;
    bit          cut;
    goal = budget_items + count;
    while (budget_items < goal) begin
      text_q.delete();
      cut = 1'b0;
      case ($urandom_range(0, 19))
        0: ;
        1: begin
          // Printable text right at the length limit, one byte either side.
          if (lim_len <= 16'd80) begin
            n = int'(lim_len) + $urandom_range(0, 2) - 1;
            repeat (n) text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
          end else begin
            put_good();
          end
        end
        2, 3, 4, 5, 6: begin
          repeat ($urandom_range(0, 3)) put_good();
          put_fault(cut);
          if (!cut) repeat ($urandom_range(0, 2)) put_good();
        end
        default: repeat ($urandom_range(1, 6)) put_good();
      endcase
      emit_text(1'b1, $urandom_range(0, 4) == 0);
    end
  endtask

  task automatic load_directed();
    push_item(8'h20, 1'b0, 1'b0);
    push_item(8'hA5, 1'b0, 1'b1);
    push_item(8'h7E, 1'b0, 1'b0);
    push_item(8'h5A, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    text_q = '{8'h00, 8'h41};                emit_text(1'b0, 1'b0);
    text_q = '{8'h41, DelByte};              emit_text(1'b0, 1'b0);
    text_q = '{8'hC2, 8'h80};                emit_text(1'b0, 1'b0);
    text_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};  emit_text(1'b0, 1'b0);
    text_q = '{8'hC1, 8'hBF};                emit_text(1'b0, 1'b0);
    text_q = '{8'hED, 8'hA0, 8'h80};         emit_text(1'b0, 1'b0);
    text_q = '{8'hF4, 8'h90, 8'h80, 8'h80};  emit_text(1'b0, 1'b0);
    text_q = '{8'hFF};                       emit_text(1'b0, 1'b0);
    text_q = '{8'hE2, 8'h41};                emit_text(1'b0, 1'b0);
    text_q = '{8'hE2, 8'h82};                emit_text(1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (items_taken != items_loaded || verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_max_length(input logic [LenW-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    lim_len = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct  = 15;
    stall_pct = 15;
    load_directed();
    load_random(120);
    wait_drained();

    idle_pct  = 40;
    stall_pct = 40;
    set_max_length(16'd1);
    load_random(70);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 25;
    set_max_length(LenW'($urandom_range(2, 20)));
    load_random(100);
    wait_drained();

    // Last stretch runs flat out under the widest length limit.
    quiet_tail = 1'b1;
    set_max_length(16'hFFFF);
    load_random(100);
    wait_drained();

    $display("Checked %0d verdicts (%0d accepting) from %0d input transfers", verdicts_seen,
             verdicts_true, items_taken);
    $display("over length limits of 64, 1, a small random value and 65535.");
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d verdicts outstanding.", verdicts_due.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
